// ===== rtl/core/imufp_pkg.sv =====
`default_nettype none

package imufp_pkg;

   localparam int PACKET_BYTES   = 16;
   localparam int MAX_FIFO_BYTES = 2048;
   localparam int HEADER_BIT     = 7;

   localparam logic [15:0] MAX_SAMPLES_RESET = 16'd16;
   localparam logic [15:0] PERIOD_RESET      = 16'd1000;

   localparam logic KIND_BATCH = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   localparam logic CSR_MAX_SAMPLES = 1'b0;
   localparam logic CSR_PERIOD      = 1'b1;

   typedef enum logic [2:0] {
      ST_BATCH_OK     = 3'd0,
      ST_BATCH_REJECT = 3'd1,
      ST_SAMPLE       = 3'd2,
      ST_HEADER_DROP  = 3'd3,
      ST_ONES_DROP    = 3'd4
   } status_type;

   typedef logic [7:0] byte_type;

endpackage

`default_nettype wire

// ===== rtl/core/imu_fifo_packet_unpacker.sv =====
`default_nettype none

// Unpacks 16-byte IMU FIFO packets. A batch-start word (kind 0) loads the FIFO
// byte count and batch time and always answers with one result; each data word
// (kind 1) in an active batch adds one byte, and the sixteenth byte of a packet
// answers with a sample or a drop status. The block takes one word per clock while
// results are taken: words pass an input register and the parse logic, and
// results sit in an output register. While a result waits, the input register
// takes at most one more word and the input then stalls until that result is
// taken. The sample timestamp uses a registered 16x16 product of accepted count
// and period, refreshed every cycle. The user must write max_samples and
// sample_period_us through the csr port while idle; the block does not enforce it.
module imu_fifo_packet_unpacker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_kind,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic [15:0]         req_fifo_count,
   input  wire logic [31:0]         req_batch_time_us,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_status,
   output logic signed [15:0]       rsp_accel_x,
   output logic signed [15:0]       rsp_accel_y,
   output logic signed [15:0]       rsp_accel_z,
   output logic signed [15:0]       rsp_gyro_x,
   output logic signed [15:0]       rsp_gyro_y,
   output logic signed [15:0]       rsp_gyro_z,
   output logic signed [7:0]        rsp_temperature,
   output logic [31:0]              rsp_timestamp_us,
   output logic                     rsp_want_more
);
   import imufp_pkg::*;

   // configuration
   logic [15:0] max_samples_ff;
   logic [15:0] period_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_kind_ff;
   logic [7:0]  s1_data_ff;
   logic [15:0] s1_count_ff;
   logic [31:0] s1_time_ff;

   // parse state
   byte_type    pkt_bytes_ff [PACKET_BYTES];
   logic        pkt_we;
   logic [3:0]  pos_ff, pos_in;
   logic [11:0] remaining_ff, remaining_in;
   logic [15:0] accepted_ff, accepted_in;
   logic [31:0] start_time_ff, start_time_in;
   logic        active_ff, active_in;
   logic [31:0] prod_ff, prod_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [15:0] axis_ff [6];
   logic [15:0] axis_in [6];
   logic [7:0]  temp_ff, temp_in;
   logic [31:0] ts_ff, ts_in;
   logic        want_ff, want_in;

   logic        advance;
   logic        all_ones;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign prod_in   = 32'(accepted_ff) * 32'(period_ff);

   always_comb begin
      all_ones = 1'b1;
      for (int k = 1; k <= 12; k++) begin
         all_ones = all_ones & (&pkt_bytes_ff[k]);
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff && !advance;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end
      pkt_we        = 1'b0;
      pos_in        = pos_ff;
      remaining_in  = remaining_ff;
      accepted_in   = accepted_ff;
      start_time_in = start_time_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      for (int k = 0; k < 6; k++) begin
         axis_in[k] = axis_ff[k];
      end
      temp_in       = temp_ff;
      ts_in         = ts_ff;
      want_in       = want_ff;

      if (s1_valid_ff && advance) begin
         if (s1_kind_ff == KIND_BATCH) begin
            pos_in       = '0;
            accepted_in  = '0;
            rsp_valid_in = 1'b1;
            for (int k = 0; k < 6; k++) begin
               axis_in[k] = '0;
            end
            temp_in      = '0;
            if (s1_count_ff > 16'(MAX_FIFO_BYTES)) begin
               remaining_in = '0;
               active_in    = 1'b0;
               status_in    = ST_BATCH_REJECT;
               ts_in        = '0;
               want_in      = 1'b0;
            end else begin
               remaining_in  = s1_count_ff[11:0];
               start_time_in = s1_time_ff;
               active_in     = (s1_count_ff[11:0] >= 12'(PACKET_BYTES))
                               && (max_samples_ff != 16'd0);
               status_in     = ST_BATCH_OK;
               ts_in         = s1_time_ff;
               want_in       = active_in;
            end
         end else if (active_ff) begin
            pkt_we = 1'b1;
            pos_in = pos_ff + 4'd1;
            if (pos_ff == 4'(PACKET_BYTES - 1)) begin
               remaining_in = remaining_ff - 12'(PACKET_BYTES);
               rsp_valid_in = 1'b1;
               for (int k = 0; k < 6; k++) begin
                  axis_in[k] = '0;
               end
               temp_in = '0;
               ts_in   = '0;
               if (pkt_bytes_ff[0][HEADER_BIT]) begin
                  status_in = ST_HEADER_DROP;
               end else if (all_ones) begin
                  status_in = ST_ONES_DROP;
               end else begin
                  status_in = ST_SAMPLE;
                  for (int k = 0; k < 6; k++) begin
                     axis_in[k] = {pkt_bytes_ff[1 + 2 * k], pkt_bytes_ff[2 + 2 * k]};
                  end
                  temp_in     = pkt_bytes_ff[13];
                  ts_in       = start_time_ff + prod_ff;
                  accepted_in = accepted_ff + 16'd1;
               end
               active_in = (remaining_in >= 12'(PACKET_BYTES))
                           && (accepted_in < max_samples_ff);
               want_in   = active_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_samples_ff <= MAX_SAMPLES_RESET;
         period_ff      <= PERIOD_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MAX_SAMPLES) begin
            max_samples_ff <= csr_wdata;
         end else begin
            period_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         remaining_ff <= '0;
         accepted_ff  <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pos_ff       <= pos_in;
         remaining_ff <= remaining_in;
         accepted_ff  <= accepted_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // batch_start_time resets to zero like pos, remaining, accepted and active
   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
      end else begin
         start_time_ff <= start_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_kind_ff  <= req_kind;
         s1_data_ff  <= req_data_byte;
         s1_count_ff <= req_fifo_count;
         s1_time_ff  <= req_batch_time_us;
      end
      if (pkt_we) begin
         pkt_bytes_ff[pos_ff] <= s1_data_ff;
      end
      prod_ff   <= prod_in;
      status_ff <= status_in;
      for (int k = 0; k < 6; k++) begin
         axis_ff[k] <= axis_in[k];
      end
      temp_ff <= temp_in;
      ts_ff   <= ts_in;
      want_ff <= want_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_accel_x      = axis_ff[0];
   assign rsp_accel_y      = axis_ff[1];
   assign rsp_accel_z      = axis_ff[2];
   assign rsp_gyro_x       = axis_ff[3];
   assign rsp_gyro_y       = axis_ff[4];
   assign rsp_gyro_z       = axis_ff[5];
   assign rsp_temperature  = temp_ff;
   assign rsp_timestamp_us = ts_ff;
   assign rsp_want_more    = want_ff;

   // no partial packet survives while no batch is active
   a_idle_pos_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> pos_ff == 4'd0)
      else $error("partial packet while batch inactive");

   // the shown want_more tracks the live batch state
   a_want_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> want_ff == active_ff)
      else $error("want_more disagrees with batch state");

   a_reject_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_BATCH_REJECT |-> !active_ff && remaining_ff == 12'd0)
      else $error("rejected batch left active");

   a_sample_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_SAMPLE |-> accepted_ff != 16'd0)
      else $error("sample shown without accepted count");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import imufp_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS   = 150;

   typedef struct packed {
      status_type       status;
      logic [5:0][15:0] axes;
      byte_type         temperature;
      logic [31:0]      timestamp;
      logic             want_more;
   } unpack_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [15:0] csr_wdata;
   logic req_valid;
   logic req_ready;
   logic req_kind;
   logic [7:0] req_data_byte;
   logic [15:0] req_fifo_count;
   logic [31:0] req_batch_time_us;
   logic rsp_valid;
   logic rsp_ready;
   logic [2:0] rsp_status;
   logic signed [15:0] rsp_accel_x;
   logic signed [15:0] rsp_accel_y;
   logic signed [15:0] rsp_accel_z;
   logic signed [15:0] rsp_gyro_x;
   logic signed [15:0] rsp_gyro_y;
   logic signed [15:0] rsp_gyro_z;
   logic signed [7:0] rsp_temperature;
   logic [31:0] rsp_timestamp_us;
   logic rsp_want_more;

   // shadow of the parser state
   logic [15:0] cfg_max_samples;
   logic [15:0] cfg_period;
   byte_type    pkt_buf [16];
   logic [3:0]  pkt_pos;
   logic [11:0] bytes_left;
   logic [15:0] samples_taken;
   logic [31:0] batch_t0;
   logic        batch_open;

   unpack_result_type expected_results [$];
   int mismatches;
   int useful_words;
   bit req_bursty;
   bit rsp_bursty;
   int rsp_hold_cycles;
   string axis_names [6] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

   imu_fifo_packet_unpacker u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_data_byte     (req_data_byte),
      .req_fifo_count    (req_fifo_count),
      .req_batch_time_us (req_batch_time_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_accel_x       (rsp_accel_x),
      .rsp_accel_y       (rsp_accel_y),
      .rsp_accel_z       (rsp_accel_z),
      .rsp_gyro_x        (rsp_gyro_x),
      .rsp_gyro_y        (rsp_gyro_y),
      .rsp_gyro_z        (rsp_gyro_z),
      .rsp_temperature   (rsp_temperature),
      .rsp_timestamp_us  (rsp_timestamp_us),
      .rsp_want_more     (rsp_want_more)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic bit more_packets();
      return bytes_left >= 12'(PACKET_BYTES) && samples_taken < cfg_max_samples;
   endfunction

   task automatic predict_unpack(input logic kind, input byte_type data,
                                 input logic [15:0] count, input logic [31:0] t,
                                 output bit used);
      unpack_result_type r;
      bit ones;
      r = '0;
      used = 1'b1;
      if (kind == KIND_BATCH) begin
         pkt_pos = '0;
         samples_taken = '0;
         if (count > MAX_FIFO_BYTES) begin
            bytes_left = '0;
            batch_open = 1'b0;
            r.status = ST_BATCH_REJECT;
         end else begin
            bytes_left = count[11:0];
            batch_t0 = t;
            batch_open = more_packets();
            r.status = ST_BATCH_OK;
            r.timestamp = t;
            r.want_more = batch_open;
         end
         expected_results.push_back(r);
         return;
      end
      if (!batch_open) begin
         used = 1'b0;
         return;
      end
      pkt_buf[pkt_pos] = data;
      pkt_pos = pkt_pos + 4'd1;
      if (pkt_pos != 4'd0)
         return;
      bytes_left = bytes_left - 12'(PACKET_BYTES);
      if (pkt_buf[0][HEADER_BIT]) begin
         r.status = ST_HEADER_DROP;
      end else begin
         ones = 1'b1;
         for (int i = 0; i < 6; i++)
            if ({pkt_buf[1 + 2 * i], pkt_buf[2 + 2 * i]} != 16'hFFFF)
               ones = 1'b0;
         if (ones) begin
            r.status = ST_ONES_DROP;
         end else begin
            r.status = ST_SAMPLE;
            for (int i = 0; i < 6; i++)
               r.axes[i] = {pkt_buf[1 + 2 * i], pkt_buf[2 + 2 * i]};
            r.temperature = pkt_buf[13];
            r.timestamp = batch_t0 + 32'(samples_taken) * 32'(cfg_period);
            samples_taken = samples_taken + 16'd1;
         end
      end
      batch_open = more_packets();
      r.want_more = batch_open;
      expected_results.push_back(r);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      unpack_result_type want;
      logic [5:0][15:0] got_axes;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual status %0d timestamp %0h",
                     $time, rsp_status, rsp_timestamp_us);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            got_axes = {rsp_gyro_z, rsp_gyro_y, rsp_gyro_x, rsp_accel_z, rsp_accel_y, rsp_accel_x};
            check_field("status", {29'b0, want.status}, {29'b0, rsp_status});
            for (int i = 0; i < 6; i++)
               check_field(axis_names[i], {16'b0, want.axes[i]}, {16'b0, got_axes[i]});
            check_field("temperature", {24'b0, want.temperature}, {24'b0, rsp_temperature});
            check_field("timestamp_us", want.timestamp, rsp_timestamp_us);
            check_field("want_more", {31'b0, want.want_more}, {31'b0, rsp_want_more});
         end
      end
   end

   // result side: random stalls, bursts, and an occasional long hold-off
   initial begin : rsp_side
      int stall;
      bit took;
      rsp_ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         took = rsp_valid && rsp_ready;
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (took) begin
            stall = rsp_bursty ? 0 : $urandom_range(0, 14);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic kind, input byte_type data,
                            input logic [15:0] count, input logic [31:0] t);
      int gap;
      bit used;
      gap = req_bursty ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_data_byte <= data;
      req_fifo_count <= count;
      req_batch_time_us <= t;
      do @(posedge clock); while (!req_ready);
      predict_unpack(kind, data, count, t, used);
      if (used)
         useful_words++;
      @(negedge clock);
   endtask

   task automatic send_data(input byte_type data);
      send_word(KIND_DATA, data, 16'($urandom), $urandom);
   endtask

   task automatic send_packet(input byte_type pkt [16]);
      foreach (pkt[i])
         send_data(pkt[i]);
   endtask

   task automatic send_random_packet();
      byte_type pkt [16];
      int flavor;
      flavor = $urandom_range(0, 9);
      foreach (pkt[i])
         pkt[i] = 8'($urandom);
      pkt[0][HEADER_BIT] = (flavor < 2);
      if (flavor >= 1 && flavor <= 3)
         for (int i = 1; i <= 12; i++)
            pkt[i] = 8'hFF;
      // one bit short of an all-ones packet
      if (flavor == 3)
         pkt[$urandom_range(1, 12)][$urandom_range(0, 7)] = 1'b0;
      send_packet(pkt);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] max_samples, input logic [15:0] period);
      csr_we <= 1'b1;
      csr_index <= CSR_MAX_SAMPLES;
      csr_wdata <= max_samples;
      @(negedge clock);
      csr_index <= CSR_PERIOD;
      csr_wdata <= period;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_max_samples = max_samples;
      cfg_period = period;
   endtask

   task automatic test_batch_framing();
      byte_type pkt [16];
      pkt = '{8'h01, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF,
              8'h00, 8'h00, 8'h00, 8'h02, 8'h7F, 8'h00, 8'hFF};
      send_word(KIND_BATCH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(KIND_DATA, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(KIND_BATCH, 8'h00, 16'd2049, 32'h0);
      send_word(KIND_BATCH, 8'h00, 16'd15, 32'h1234_5678);
      send_data(8'h00);
      send_word(KIND_BATCH, 8'h00, 16'd2048, 32'hFFFF_FFF0);
      repeat (5) send_data(8'($urandom));
      // new batch throws away the five bytes above
      send_word(KIND_BATCH, 8'h00, 16'd16, 32'h0);
      send_packet(pkt);
      send_data(8'hA5);
      drain();
   endtask

   task automatic test_packet_kinds();
      byte_type extremes [16];
      byte_type flagged [16];
      byte_type all_ones [16];
      byte_type plain [16];
      extremes = '{8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                   8'h12, 8'h34, 8'hFF, 8'hFE, 8'h80, 8'hAA, 8'h55};
      flagged  = '{8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
      all_ones = '{8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h19, 8'h00, 8'h00};
      plain    = '{8'h7F, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                   8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h7F, 8'h0E, 8'h0F};
      // second sample's timestamp wraps past 2^32
      send_word(KIND_BATCH, 8'h00, 16'd64, 32'hFFFF_FE00);
      send_packet(extremes);
      send_packet(flagged);
      send_packet(all_ones);
      send_packet(plain);
      drain();
   endtask

   task automatic test_config_corners();
      set_config(16'd0, 16'd1000);
      send_word(KIND_BATCH, 8'h00, 16'd32, 32'h0000_1000);
      send_data(8'h00);
      drain();
      set_config(16'd1, 16'd0);
      send_word(KIND_BATCH, 8'h00, 16'd48, 32'h8000_0000);
      send_random_packet();
      send_data(8'h00);
      drain();
      set_config(16'd3, 16'd0);
      send_word(KIND_BATCH, 8'h00, 16'd80, $urandom);
      while (batch_open)
         send_random_packet();
      drain();
      set_config(16'hFFFF, 16'hFFFF);
      send_word(KIND_BATCH, 8'h00, 16'd32, 32'hFFFF_0000);
      while (batch_open)
         send_random_packet();
      drain();
   endtask

   task automatic test_output_backpressure();
      set_config(16'hFFFF, 16'd3);
      rsp_hold_cycles = 200;
      req_bursty = 1'b1;
      send_word(KIND_BATCH, 8'h00, 16'd160, $urandom);
      while (batch_open)
         send_random_packet();
      req_bursty = 1'b0;
      drain();
   endtask

   task automatic random_batch();
      logic [15:0] count;
      int shape;
      req_bursty = ($urandom_range(0, 3) == 0);
      rsp_bursty = ($urandom_range(0, 3) == 0);
      shape = $urandom_range(0, 39);
      if (shape < 2)
         count = 16'($urandom_range(2049, 65535));
      else if (shape == 2)
         count = 16'($urandom_range(0, 2048));
      else if (shape == 3)
         count = 16'd2048;
      else if (shape < 10)
         count = 16'($urandom_range(0, 12) * 16 + $urandom_range(0, 15));
      else
         count = 16'($urandom_range(0, 12) * 16);
      send_word(KIND_BATCH, 8'($urandom), count, $urandom);
      while (batch_open) begin
         if ($urandom_range(0, 29) == 0) begin
            // cut off mid-packet; unless the stray bytes below complete it, the next batch start discards it
            repeat ($urandom_range(1, 15)) send_data(8'($urandom));
            break;
         end
         send_random_packet();
      end
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) send_data(8'($urandom));
   endtask

   task automatic test_random_traffic();
      logic [15:0] max_list [7];
      logic [15:0] period_list [7];
      int phase_start;
      max_list = '{16'hFFFF, 16'd0, 16'd1, 16'd16, 16'd2, 16'($urandom),
                   16'($urandom_range(1, 40))};
      period_list = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd1000, 16'd0, 16'($urandom),
                      16'($urandom)};
      for (int p = 0; p < 7; p++) begin
         set_config(max_list[p], period_list[p]);
         phase_start = useful_words;
         while (useful_words - phase_start < PHASE_WORDS)
            random_batch();
         req_bursty = 1'b0;
         rsp_bursty = 1'b0;
         drain();
      end
   endtask

   initial begin : main
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_MAX_SAMPLES;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_kind = KIND_BATCH;
      req_data_byte = '0;
      req_fifo_count = '0;
      req_batch_time_us = '0;
      cfg_max_samples = MAX_SAMPLES_RESET;
      cfg_period = PERIOD_RESET;
      foreach (pkt_buf[i])
         pkt_buf[i] = '0;
      pkt_pos = '0;
      bytes_left = '0;
      samples_taken = '0;
      batch_t0 = '0;
      batch_open = 1'b0;
      mismatches = 0;
      useful_words = 0;
      req_bursty = 1'b0;
      rsp_bursty = 1'b0;
      rsp_hold_cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_batch_framing();
      test_packet_kinds();
      test_config_corners();
      test_output_backpressure();
      test_random_traffic();
      drain();

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
